// ----- rtl/core/gfi_pkg.sv -----
// ----------------------------------------------------------------------------
// GF(2^10) inverse package
// Field constants and the carry-less multiply/square helpers used by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package gfi_pkg;

   localparam int unsigned FieldBits = 10;
   localparam logic [FieldBits:0] FieldPoly = 11'b100_0000_1001;

   typedef logic [FieldBits-1:0] elem_type;

   // Reduce a product of two field elements modulo the field polynomial.
   function automatic elem_type gf_reduce(input logic [2*FieldBits-2:0] v);
      logic [2*FieldBits-2:0] acc;
      acc = v;
      for (int i = 2*FieldBits-2; i >= FieldBits; i--) begin
         if (acc[i]) begin
            acc = acc ^ ((2*FieldBits-1)'(FieldPoly) << (i - FieldBits));
         end
      end
      return acc[FieldBits-1:0];
   endfunction

   function automatic elem_type gf_mul(input elem_type a, input elem_type b);
      logic [2*FieldBits-2:0] acc;
      acc = '0;
      for (int i = 0; i < FieldBits; i++) begin
         if (b[i]) begin
            acc = acc ^ ((2*FieldBits-1)'(a) << i);
         end
      end
      return gf_reduce(acc);
   endfunction

   // Squaring over GF(2) only spreads the bits apart; the result is then reduced.
   function automatic elem_type gf_sqr(input elem_type a);
      logic [2*FieldBits-2:0] acc;
      acc = '0;
      for (int i = 0; i < FieldBits; i++) begin
         acc[2*i] = a[i];
      end
      return gf_reduce(acc);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gf1024_inverse.sv -----
// Each accepted request beat is registered in the nine power cells and then in the final squaring register.
// Throughput: one beat per cycle; the chain of nine power cells and the final
// squaring register advance together and stall together when the response waits.
// Reset clears all valid flags; element and power registers are not reset.
// A zero element yields zero since every power of zero is zero.
// ----------------------------------------------------------------------------
// GF(2^10) inverse
// Computes element^1022, the inverse modulo x^10+x^3+1, through a cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module gf1024_inverse
   import gfi_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [9:0] req_element,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [9:0]      rsp_inverse
);

   localparam int unsigned NumCells = FieldBits - 1;

   logic     enable;
   logic     valid_c [NumCells+1];
   elem_type elem_c  [NumCells+1];
   elem_type power_c [NumCells+1];
   logic     rsp_valid_ff;
   elem_type rsp_inverse_ff;

   assign enable     = !rsp_valid_ff || rsp_ready;
   assign req_ready  = enable;
   assign valid_c[0] = req_valid;
   assign elem_c[0]  = req_element;
   assign power_c[0] = elem_type'(1);

   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      gfi_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .valid_i (valid_c[g]),
         .elem_i  (elem_c[g]),
         .power_i (power_c[g]),
         .valid_o (valid_c[g+1]),
         .elem_o  (elem_c[g+1]),
         .power_o (power_c[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= valid_c[NumCells];
      end
   end

   // element^511 squared gives element^1022.
   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_inverse_ff <= gf_sqr(power_c[NumCells]);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_inverse = rsp_inverse_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gfi_cell.sv -----
// ----------------------------------------------------------------------------
// GF(2^10) inverse cell
// One step of the power chain: the running power is squared and multiplied by
// the element, so after k cells it holds element^(2^k - 1).
// ----------------------------------------------------------------------------
`default_nettype none

module gfi_cell
   import gfi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     enable,
   input  wire logic     valid_i,
   input  wire elem_type elem_i,
   input  wire elem_type power_i,
   output logic          valid_o,
   output elem_type      elem_o,
   output elem_type      power_o
);

   logic     valid_ff;
   elem_type elem_ff;
   elem_type power_ff;
   elem_type power_in;

   assign power_in = gf_mul(gf_sqr(power_i), elem_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         elem_ff  <= elem_i;
         power_ff <= power_in;
      end
   end

   assign valid_o = valid_ff;
   assign elem_o  = elem_ff;
   assign power_o = power_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gfi_checker.sv -----
// ----------------------------------------------------------------------------
// GF(2^10) inverse checker
// Port-level assertions on the inverse block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gfi_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [9:0] req_element,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [9:0] rsp_inverse
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_element))
      else $error("request beat withdrawn or changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_inverse))
      else $error("response payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind gf1024_inverse gfi_checker u_gfi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_element (req_element),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_inverse (rsp_inverse)
);

`default_nettype wire
